### design/rc5_pkg.sv
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared types, constants and word functions for the RC5-16 block cipher.
// ----------------------------------------------------------------------------
package rc5_pkg;

	// 16-bit cipher word
	typedef logic [15:0] word_t;

	// key schedule magic constants
	localparam word_t P16 = 16'hB7E1;
	localparam word_t Q16 = 16'h9E37;

	// key words (128-bit key as eight 16-bit words)
	localparam int KEY_WORDS = 8;
	localparam int KEY_AW    = 3;

	// key schedule rotate amount for the subkey mix
	localparam logic [3:0] MIX_ROT = 4'd3;

	// configuration register indexes
	localparam int               CFG_IDX_W    = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

	// operation codes
	localparam logic FUNC_ENC = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic key_lo_wr;
		logic key_hi_wr;
		logic in_load;
		logic use_in;
		logic fill_init;
		logic fill_step;
		logic mix_rd;
		logic mix_wr;
		logic blk_start;
		logic blk_step;
		logic out_load;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic fill_last;
		logic mix_last;
		logic run_last;
	} dp_sts_t;

	// rotate left, low four bits of the amount count
	function automatic word_t rotl(input word_t v, input logic [3:0] s);
		logic [31:0] t;
		t = {v, v} << s;
		return t[31:16];
	endfunction

	// rotate right, low four bits of the amount count
	function automatic word_t rotr(input word_t v, input logic [3:0] s);
		logic [31:0] t;
		t = {v, v} >> s;
		return t[15:0];
	endfunction

endpackage

### design/rc5_ctrl.sv
// ----------------------------------------------------------------------------
// rc5_ctrl
// Sequencer for key expansion and block rounds; owns the handshake flags.
// ----------------------------------------------------------------------------
module rc5_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         cfg_valid,
	input  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_index,
	output rc5_pkg::ctl_cmd_t            cmd,
	input  rc5_pkg::dp_sts_t             sts
);
	import rc5_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_MIX_RD,
		ST_MIX_WR,
		ST_LOAD,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   table_ready_q, table_ready_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;

	// output register can take a result this cycle
	assign out_free = !out_valid_q || !out_stall;

	// next state and command decode
	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		table_ready_d = table_ready_q;
		out_valid_d   = out_valid_q;

		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		// key writes mark the subkey table stale
		if (cfg_valid && cfg_index == CFG_KEY_LOW) begin
			cmd.key_lo_wr = 1'b1;
			table_ready_d = 1'b0;
		end
		if (cfg_valid && cfg_index == CFG_KEY_HIGH) begin
			cmd.key_hi_wr = 1'b1;
			table_ready_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					if (table_ready_q) begin
						cmd.blk_start = 1'b1;
						cmd.use_in    = 1'b1;
						state_d       = ST_RUN;
					end else begin
						cmd.fill_init = 1'b1;
						state_d       = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = ST_MIX_RD;
				end
			end
			ST_MIX_RD: begin
				cmd.mix_rd = 1'b1;
				state_d    = ST_MIX_WR;
			end
			ST_MIX_WR: begin
				cmd.mix_wr = 1'b1;
				if (sts.mix_last) begin
					table_ready_d = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					state_d = ST_MIX_RD;
				end
			end
			ST_LOAD: begin
				cmd.blk_start = 1'b1;
				state_d       = ST_RUN;
			end
			ST_RUN: begin
				cmd.blk_step = 1'b1;
				if (sts.run_last) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						out_valid_d  = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			table_ready_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			table_ready_q <= table_ready_d;
			out_valid_q   <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### design/rc5_dpath.sv
// ----------------------------------------------------------------------------
// rc5_dpath
// Key registers, subkey memory, key schedule and round datapath.
// ----------------------------------------------------------------------------
module rc5_dpath #(
	parameter int ROUNDS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rc5_pkg::ctl_cmd_t cmd,
	output rc5_pkg::dp_sts_t  sts,
	input  logic [63:0]       cfg_data,
	input  logic              func,
	input  logic [31:0]       block_in,
	output logic [31:0]       block_out
);
	import rc5_pkg::*;

	localparam int SUBKEYS   = 2 * ROUNDS + 2;
	localparam int MIX_STEPS = 3 * ((SUBKEYS > KEY_WORDS) ? SUBKEYS : KEY_WORDS);
	localparam int AW        = $clog2(SUBKEYS);
	localparam int MW        = $clog2(MIX_STEPS);
	localparam int PW        = AW - 1;

	// key registers
	logic [63:0] key_low_q, key_high_q;

	// subkey memory and its registered read ports
	word_t       subkey_q [SUBKEYS];
	word_t       rd0_q, rd1_q;
	logic [AW-1:0] ra0, ra1, wa;
	word_t       wd;
	logic        we;

	// key schedule state
	word_t       words_q [KEY_WORDS];
	logic [AW-1:0] i_q;
	logic [KEY_AW-1:0] j_q;
	logic [MW-1:0] mcnt_q;
	word_t       fval_q;
	word_t       ma_q, mb_q;
	word_t       ma_nx, mb_nx;

	// block state
	logic        func_q;
	logic [31:0] block_q;
	logic        run_func_q;
	logic [PW-1:0] p_q, p_nx, p_start;
	word_t       a_q, b_q, a_nx, b_nx;
	logic [31:0] block_out_q;
	logic        start_func;

	// key register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else begin
			if (cmd.key_lo_wr) key_low_q <= cfg_data;
			if (cmd.key_hi_wr) key_high_q <= cfg_data;
		end
	end

	// schedule mix step
	always_comb begin
		word_t sum_b;
		ma_nx = rotl(rd0_q + ma_q + mb_q, MIX_ROT);
		sum_b = ma_nx + mb_q;
		mb_nx = rotl(words_q[j_q] + sum_b, sum_b[3:0]);
	end

	// pair to fetch next
	assign start_func = cmd.use_in ? func : func_q;
	assign p_start    = (start_func == FUNC_DEC) ? PW'(ROUNDS) : '0;
	always_comb begin
		if (cmd.blk_start) begin
			p_nx = p_start;
		end else if (run_func_q == FUNC_DEC) begin
			p_nx = p_q - 1'b1;
		end else begin
			p_nx = p_q + 1'b1;
		end
	end

	// memory ports
	assign ra0 = cmd.mix_rd ? i_q : AW'({p_nx, 1'b0});
	assign ra1 = AW'({p_nx, 1'b1});
	assign we  = cmd.fill_step || cmd.mix_wr;
	assign wa  = i_q;
	assign wd  = cmd.fill_step ? fval_q : ma_nx;

	always_ff @(posedge clk) begin
		if (we) subkey_q[wa] <= wd;
		rd0_q <= subkey_q[ra0];
		rd1_q <= subkey_q[ra1];
	end

	// key schedule sequencing
	always_ff @(posedge clk) begin
		if (cmd.fill_init) begin
			for (int k = 0; k < KEY_WORDS / 2; k++) begin
				words_q[k]                 <= key_low_q[16*k +: 16];
				words_q[k + KEY_WORDS / 2] <= key_high_q[16*k +: 16];
			end
			i_q    <= '0;
			j_q    <= '0;
			mcnt_q <= '0;
			fval_q <= P16;
			ma_q   <= '0;
			mb_q   <= '0;
		end else if (cmd.fill_step || cmd.mix_wr) begin
			i_q <= (i_q == AW'(SUBKEYS - 1)) ? '0 : i_q + 1'b1;
			if (cmd.fill_step) begin
				fval_q <= fval_q + Q16;
			end else begin
				ma_q           <= ma_nx;
				mb_q           <= mb_nx;
				words_q[j_q]   <= mb_nx;
				j_q            <= j_q + 1'b1;
				mcnt_q         <= mcnt_q + 1'b1;
			end
		end
	end

	// one round, or the whitening step at pair zero
	always_comb begin
		word_t t;
		t    = '0;
		a_nx = a_q;
		b_nx = b_q;
		if (run_func_q == FUNC_ENC) begin
			if (p_q == '0) begin
				a_nx = a_q + rd0_q;
				b_nx = b_q + rd1_q;
			end else begin
				t    = rotl(a_q ^ b_q, b_q[3:0]) + rd0_q;
				a_nx = t;
				b_nx = rotl(b_q ^ t, t[3:0]) + rd1_q;
			end
		end else begin
			if (p_q == '0) begin
				a_nx = a_q - rd0_q;
				b_nx = b_q - rd1_q;
			end else begin
				t    = rotr(b_q - rd1_q, a_q[3:0]) ^ a_q;
				b_nx = t;
				a_nx = rotr(a_q - rd0_q, t[3:0]) ^ t;
			end
		end
	end

	// block registers
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			func_q  <= func;
			block_q <= block_in;
		end
		if (cmd.blk_start) begin
			run_func_q <= start_func;
			p_q        <= p_start;
			a_q        <= cmd.use_in ? block_in[31:16] : block_q[31:16];
			b_q        <= cmd.use_in ? block_in[15:0] : block_q[15:0];
		end else if (cmd.blk_step) begin
			p_q <= p_nx;
			a_q <= a_nx;
			b_q <= b_nx;
		end
		if (cmd.out_load) begin
			block_out_q <= cmd.blk_step ? {a_nx, b_nx} : {a_q, b_q};
		end
	end

	// status
	assign sts.fill_last = (i_q == AW'(SUBKEYS - 1));
	assign sts.mix_last  = (mcnt_q == MW'(MIX_STEPS - 1));
	assign sts.run_last  = (run_func_q == FUNC_DEC) ? (p_q == '0) : (p_q == PW'(ROUNDS));

	assign block_out = block_out_q;

endmodule

### design/rc5_16_20_block_cipher.sv
// ----------------------------------------------------------------------------
// rc5_16_20_block_cipher
// RC5 with 16-bit words and a 128-bit key on 32-bit blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func (0 encrypt, 1 decrypt)
//   and block_in; half A is block_in[31:16], half B is block_in[15:0].
//   Output channel (out_valid/out_stall) returns block_out, same packing.
//   Config channel (cfg_valid/cfg_ready, always ready) writes key_low at
//   index 0 and key_high at index 1; other indexes are ignored. Write the
//   key only while the block is idle.
//   A request is accepted only while the block is idle, so the next one
//   waits until the previous result is loaded; the round unit does one
//   round per cycle from a dual-read subkey memory.
//   After a key write the first request also pays for key expansion:
//   a fill of 2*ROUNDS+2 subkeys, then 3*max(2*ROUNDS+2,8) mix steps that
//   each pass through a read and a write state, then a block load state.
//   Reset clears the key to zero and marks the subkey table stale.
//   A stalled result sits in the output register; the next request is
//   still accepted and runs, then waits until the output register frees.
// ----------------------------------------------------------------------------
module rc5_16_20_block_cipher #(
	parameter int ROUNDS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [31:0]                   block_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   block_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import rc5_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// key registers accept a write on any cycle
	assign cfg_ready = 1'b1;

	rc5_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cmd       (cmd),
		.sts       (sts)
	);

	rc5_dpath #(
		.ROUNDS (ROUNDS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_data  (cfg_data),
		.func      (func),
		.block_in  (block_in),
		.block_out (block_out)
	);

endmodule
